### rtl/core/nsi_pkg.sv
package nsi_pkg;

    // Sample and result formats.
    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;
    localparam int SUM_WIDTH    = SAMPLE_WIDTH + FRAC_BITS;
    localparam int CNT_WIDTH    = 16;

    // Interval width, interval sum and weight coefficient widths.
    localparam int H_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int HS_WIDTH = SAMPLE_WIDTH + 2;
    localparam int MB_WIDTH = SAMPLE_WIDTH + 3;

    // Wide datapath: holds the full numerator and the shifted divisor.
    localparam int NUM_WIDTH_A = 4 * SAMPLE_WIDTH + 8;
    localparam int NUM_WIDTH_B = 3 * SAMPLE_WIDTH + 2 * FRAC_BITS + 4;
    localparam int NUM_WIDTH   = (NUM_WIDTH_A > NUM_WIDTH_B) ? NUM_WIDTH_A : NUM_WIDTH_B;

    // Step counter covers both the multiply and the divide loops.
    localparam int MAX_STEPS  = (MB_WIDTH > SUM_WIDTH) ? MB_WIDTH : SUM_WIDTH;
    localparam int STEP_WIDTH = $clog2(MAX_STEPS);

    // Saturation limits of the running sum.
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Sample counter limits: the counter steps back by one to keep its parity.
    localparam logic [CNT_WIDTH-1:0] CNT_MAX  = {CNT_WIDTH{1'b1}};
    localparam logic [CNT_WIDTH-1:0] CNT_WRAP = {{(CNT_WIDTH-1){1'b1}}, 1'b0};

    // Three consecutive samples handed to the term engine.
    typedef struct packed {
        logic                    start;
        logic [SAMPLE_WIDTH-1:0] x0;
        logic [SAMPLE_WIDTH-1:0] y0;
        logic [SAMPLE_WIDTH-1:0] x1;
        logic [SAMPLE_WIDTH-1:0] y1;
        logic [SAMPLE_WIDTH-1:0] x2;
        logic [SAMPLE_WIDTH-1:0] y2;
    } t_pair_req;

    // Term returned by the engine, with its status.
    typedef struct packed {
        logic                 done;
        logic [SUM_WIDTH-1:0] term;
        logic                 zerr;
        logic                 sat;
    } t_term_rsp;

endpackage

### rtl/core/nsi_addsub.sv
module nsi_addsub (
    input  logic [nsi_pkg::NUM_WIDTH-1:0] i_a,
    input  logic [nsi_pkg::NUM_WIDTH-1:0] i_b,
    input  logic                          i_sub,
    output logic [nsi_pkg::NUM_WIDTH-1:0] o_sum,
    output logic                          o_carry
);
    import nsi_pkg::*;

    logic [NUM_WIDTH:0] w_sum;

    // Shared wide adder. On subtraction the carry out means a >= b (unsigned).
    assign w_sum = {1'b0, i_a} + {1'b0, i_b ^ {NUM_WIDTH{i_sub}}}
                 + {{NUM_WIDTH{1'b0}}, i_sub};
    assign o_sum   = w_sum[NUM_WIDTH-1:0];
    assign o_carry = w_sum[NUM_WIDTH];

endmodule

### rtl/core/nsi_term.sv
module nsi_term (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsi_pkg::t_pair_req i_req,
    output nsi_pkg::t_term_rsp o_rsp
);
    import nsi_pkg::*;

    localparam int YEXT = NUM_WIDTH - SAMPLE_WIDTH;

    typedef enum logic [6:0] {
        E_IDLE = 7'b0000001,
        E_PREP = 7'b0000010,
        E_MUL  = 7'b0000100,
        E_NEG  = 7'b0001000,
        E_CHK  = 7'b0010000,
        E_DIV  = 7'b0100000,
        E_FIN  = 7'b1000000
    } t_estate;

    // Multiply sequence that builds the numerator and the denominator.
    typedef enum logic [2:0] {
        OP_Y0C0 = 3'd0,
        OP_H1   = 3'd1,
        OP_Y1HS = 3'd2,
        OP_HS2  = 3'd3,
        OP_Y2C2 = 3'd4,
        OP_H0   = 3'd5,
        OP_HSN  = 3'd6,
        OP_DEN  = 3'd7
    } t_op;

    t_estate r_state, n_state;
    t_op     r_op, n_op;
    logic [STEP_WIDTH-1:0]   r_cnt, n_cnt;
    logic [SAMPLE_WIDTH-1:0] r_y0, n_y0, r_y1, n_y1, r_y2, n_y2;
    logic [H_WIDTH-1:0]      r_h0, n_h0, r_h1, n_h1;
    logic [HS_WIDTH-1:0]     r_hs, n_hs;
    logic [MB_WIDTH-1:0]     r_c2, n_c2, r_h1m, n_h1m, r_mb, n_mb;
    logic [H_WIDTH+1:0]      r_h0x6, n_h0x6;
    logic [NUM_WIDTH-1:0]    r_acc, n_acc, r_ma, n_ma, r_p, n_p;
    logic [SUM_WIDTH-1:0]    r_q, n_q, r_term, n_term;
    logic                    r_neg, n_neg, r_zerr, n_zerr, r_sat, n_sat, r_done, n_done;

    logic [NUM_WIDTH-1:0] w_a, w_b, w_sum, w_prod;
    logic                 w_sub, w_carry, w_last_bit;
    logic [H_WIDTH-1:0]   w_h0m, w_h1m;
    logic [MB_WIDTH-1:0]  w_c0;

    nsi_addsub u_addsub (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign w_last_bit = (r_cnt == STEP_WIDTH'(MB_WIDTH - 1));
    assign w_prod     = r_mb[0] ? w_sum : r_acc;

    // Interval magnitudes and the first weight coefficient.
    assign w_h0m = r_h0[H_WIDTH-1] ? (~r_h0 + H_WIDTH'(1)) : r_h0;
    assign w_h1m = r_h1[H_WIDTH-1] ? (~r_h1 + H_WIDTH'(1)) : r_h1;
    assign w_c0  = {r_h0[H_WIDTH-1], r_h0, 1'b0} - {{2{r_h1[H_WIDTH-1]}}, r_h1};

    // Operand selection for the shared adder.
    always_comb begin
        w_a   = r_acc;
        w_b   = r_ma;
        w_sub = 1'b1;
        case (r_state)
            E_MUL: begin
                w_sub = w_last_bit;
            end
            E_NEG: begin
                w_a = '0;
                w_b = r_acc;
            end
            E_CHK: begin
                w_b = r_ma << SUM_WIDTH;
            end
            default: begin
                w_sub = 1'b1;
            end
        endcase
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_y0    = r_y0;
        n_y1    = r_y1;
        n_y2    = r_y2;
        n_h0    = r_h0;
        n_h1    = r_h1;
        n_hs    = r_hs;
        n_c2    = r_c2;
        n_h1m   = r_h1m;
        n_h0x6  = r_h0x6;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_ma    = r_ma;
        n_p     = r_p;
        n_q     = r_q;
        n_term  = r_term;
        n_neg   = r_neg;
        n_zerr  = r_zerr;
        n_sat   = r_sat;
        n_done  = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_y0    = i_req.y0;
                    n_y1    = i_req.y1;
                    n_y2    = i_req.y2;
                    n_h0    = {i_req.x1[SAMPLE_WIDTH-1], i_req.x1}
                            - {i_req.x0[SAMPLE_WIDTH-1], i_req.x0};
                    n_h1    = {i_req.x2[SAMPLE_WIDTH-1], i_req.x2}
                            - {i_req.x1[SAMPLE_WIDTH-1], i_req.x1};
                    n_zerr  = 1'b0;
                    n_sat   = 1'b0;
                    n_state = E_PREP;
                end
            end
            E_PREP: begin
                if (r_h0 == '0 || r_h1 == '0) begin
                    // A zero-width interval drops the whole pair.
                    n_term  = '0;
                    n_zerr  = 1'b1;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else begin
                    n_hs    = {r_h0[H_WIDTH-1], r_h0} + {r_h1[H_WIDTH-1], r_h1};
                    n_c2    = {r_h1[H_WIDTH-1], r_h1, 1'b0} - {{2{r_h0[H_WIDTH-1]}}, r_h0};
                    n_h1m   = {{(MB_WIDTH-H_WIDTH){1'b0}}, w_h1m};
                    n_h0x6  = {w_h0m, 2'b00} + {1'b0, w_h0m, 1'b0};
                    n_acc   = '0;
                    n_ma    = {{YEXT{r_y0[SAMPLE_WIDTH-1]}}, r_y0};
                    n_mb    = w_c0;
                    n_op    = OP_Y0C0;
                    n_cnt   = '0;
                    n_state = E_MUL;
                end
            end
            E_MUL: begin
                // One multiplier bit per cycle; the sign bit has negative weight.
                if (!w_last_bit) begin
                    n_acc = w_prod;
                    n_ma  = r_ma << 1;
                    n_mb  = {r_mb[MB_WIDTH-1], r_mb[MB_WIDTH-1:1]};
                    n_cnt = r_cnt + STEP_WIDTH'(1);
                end else begin
                    n_cnt = '0;
                    n_op  = t_op'(r_op + 3'd1);
                    case (r_op)
                        OP_Y0C0: begin
                            n_ma  = w_prod;
                            n_acc = '0;
                            n_mb  = {{(MB_WIDTH-H_WIDTH){r_h1[H_WIDTH-1]}}, r_h1};
                        end
                        OP_H1: begin
                            n_p   = w_prod;
                            n_ma  = {{YEXT{r_y1[SAMPLE_WIDTH-1]}}, r_y1};
                            n_acc = '0;
                            n_mb  = {{(MB_WIDTH-HS_WIDTH){r_hs[HS_WIDTH-1]}}, r_hs};
                        end
                        OP_Y1HS: begin
                            n_ma  = w_prod;
                            n_acc = r_p;
                            n_mb  = {{(MB_WIDTH-HS_WIDTH){r_hs[HS_WIDTH-1]}}, r_hs};
                        end
                        OP_HS2: begin
                            n_p   = w_prod;
                            n_ma  = {{YEXT{r_y2[SAMPLE_WIDTH-1]}}, r_y2};
                            n_acc = '0;
                            n_mb  = r_c2;
                        end
                        OP_Y2C2: begin
                            n_ma  = w_prod;
                            n_acc = r_p;
                            n_mb  = {{(MB_WIDTH-H_WIDTH){r_h0[H_WIDTH-1]}}, r_h0};
                        end
                        OP_H0: begin
                            n_ma  = w_prod;
                            n_acc = '0;
                            n_mb  = {{(MB_WIDTH-HS_WIDTH){r_hs[HS_WIDTH-1]}}, r_hs};
                        end
                        OP_HSN: begin
                            n_p   = w_prod;
                            n_ma  = {{(NUM_WIDTH-H_WIDTH-2){1'b0}}, r_h0x6};
                            n_acc = '0;
                            n_mb  = r_h1m;
                        end
                        OP_DEN: begin
                            // Divisor in the shift register, numerator in the accumulator.
                            n_ma    = w_prod << FRAC_BITS;
                            n_acc   = r_p;
                            n_state = E_NEG;
                        end
                        default: begin
                            n_state = E_IDLE;
                        end
                    endcase
                end
            end
            E_NEG: begin
                n_neg = r_acc[NUM_WIDTH-1] ^ r_h0[H_WIDTH-1] ^ r_h1[H_WIDTH-1];
                if (r_acc[NUM_WIDTH-1]) begin
                    n_acc = w_sum;
                end
                n_state = E_CHK;
            end
            E_CHK: begin
                // A quotient of more than the result width saturates at once.
                if (w_carry) begin
                    n_term  = r_neg ? SUM_MIN : SUM_MAX;
                    n_sat   = 1'b1;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else begin
                    n_ma    = r_ma << (SUM_WIDTH - 1);
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = E_DIV;
                end
            end
            E_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (w_carry) begin
                    n_acc = w_sum;
                end
                n_q  = {r_q[SUM_WIDTH-2:0], w_carry};
                n_ma = r_ma >> 1;
                if (r_cnt == STEP_WIDTH'(SUM_WIDTH - 1)) begin
                    n_state = E_FIN;
                end else begin
                    n_cnt = r_cnt + STEP_WIDTH'(1);
                end
            end
            E_FIN: begin
                if (r_neg) begin
                    if (r_q > SUM_MIN) begin
                        n_term = SUM_MIN;
                        n_sat  = 1'b1;
                    end else begin
                        n_term = ~r_q + SUM_WIDTH'(1);
                    end
                end else begin
                    if (r_q[SUM_WIDTH-1]) begin
                        n_term = SUM_MAX;
                        n_sat  = 1'b1;
                    end else begin
                        n_term = r_q;
                    end
                end
                n_done  = 1'b1;
                n_state = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_y0   <= n_y0;
        r_y1   <= n_y1;
        r_y2   <= n_y2;
        r_h0   <= n_h0;
        r_h1   <= n_h1;
        r_hs   <= n_hs;
        r_c2   <= n_c2;
        r_h1m  <= n_h1m;
        r_h0x6 <= n_h0x6;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_ma   <= n_ma;
        r_p    <= n_p;
        r_q    <= n_q;
        r_term <= n_term;
        r_neg  <= n_neg;
        r_zerr <= n_zerr;
        r_sat  <= n_sat;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.term = r_term;
    assign o_rsp.zerr = r_zerr;
    assign o_rsp.sat  = r_sat;

endmodule

### rtl/core/nonuniform_simpson_integrator.sv
// Operation: a sample that closes a pair of intervals holds the input until its term is finished
// (sooner for a zero-width interval or an oversized term): eight 35-step shift-add multiplies and a
// 48-step division on one adder. Other samples are accepted without a term computation; a last
// sample then passes through a load state, which waits while the previous result is not yet taken.
// No new sample is accepted while a pair term is being computed.
// Reset: synchronous, active low; clears the sample store, the sum, flags and valid.
module nonuniform_simpson_integrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [nsi_pkg::SAMPLE_WIDTH-1:0]    i_sample_x,
    input  logic [nsi_pkg::SAMPLE_WIDTH-1:0]    i_sample_y,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [nsi_pkg::SUM_WIDTH-1:0]       o_integral,
    output logic                                o_zero_interval_error,
    output logic                                o_saturated
);
    import nsi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [SAMPLE_WIDTH-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic [CNT_WIDTH-1:0]    r_seen;
    logic [SUM_WIDTH-1:0]    r_sum, r_out_integral;
    logic                    r_zerr, r_sat, r_last;
    logic                    r_out_valid, r_out_zerr, r_out_sat;

    logic                 w_accept, w_pair, w_load;
    logic [SUM_WIDTH:0]   w_sum_ext;
    logic [SUM_WIDTH-1:0] w_sum_sat;
    logic                 w_sum_ovf;
    t_pair_req            w_req;
    t_term_rsp            w_rsp;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_pair   = (r_seen[CNT_WIDTH-1:1] != '0) && !r_seen[0];
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    // Every sample at an even index from 2 on (the third, the fifth and so on) closes a pair of intervals.
    assign w_req.start = w_accept && w_pair;
    assign w_req.x0    = r_older_x;
    assign w_req.y0    = r_older_y;
    assign w_req.x1    = r_newer_x;
    assign w_req.y1    = r_newer_y;
    assign w_req.x2    = i_sample_x;
    assign w_req.y2    = i_sample_y;

    nsi_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Saturating accumulation of a finished term.
    assign w_sum_ext = {r_sum[SUM_WIDTH-1], r_sum} + {w_rsp.term[SUM_WIDTH-1], w_rsp.term};
    assign w_sum_ovf = w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1];
    assign w_sum_sat = w_sum_ovf ? (w_sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX)
                                 : w_sum_ext[SUM_WIDTH-1:0];

    // Control sequence.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_pair) begin
                        n_state = S_BUSY;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_BUSY: begin
                if (w_rsp.done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sample store, running sum and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_older_x <= '0;
            r_older_y <= '0;
            r_newer_x <= '0;
            r_newer_y <= '0;
            r_seen    <= '0;
            r_sum     <= '0;
            r_zerr    <= 1'b0;
            r_sat     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_older_x <= r_newer_x;
                r_older_y <= r_newer_y;
                r_newer_x <= i_sample_x;
                r_newer_y <= i_sample_y;
                r_seen    <= (r_seen == CNT_MAX) ? CNT_WRAP : r_seen + CNT_WIDTH'(1);
            end
            if (r_state == S_BUSY && w_rsp.done) begin
                r_sum  <= w_sum_sat;
                r_zerr <= r_zerr | w_rsp.zerr;
                r_sat  <= r_sat | w_rsp.sat | w_sum_ovf;
            end
        end
    end

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_last <= i_last;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; the transaction holds until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_integral <= r_sum;
            r_out_zerr     <= r_zerr;
            r_out_sat      <= r_sat;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_integral            = r_out_integral;
    assign o_zero_interval_error = r_out_zerr;
    assign o_saturated           = r_out_sat;

endmodule

### verif/simpson_result_checker.sv
module simpson_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [nsi_pkg::SAMPLE_WIDTH-1:0]  i_sample_x,
    input  logic [nsi_pkg::SAMPLE_WIDTH-1:0]  i_sample_y,
    input  logic                              i_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [nsi_pkg::SUM_WIDTH-1:0]     i_integral,
    input  logic                              i_zero_interval_error,
    input  logic                              i_saturated,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    import nsi_pkg::*;

    // Wide enough for the full Simpson numerator times the interval sum, with sign.
    localparam int WIDE = 192;
    localparam logic signed [WIDE-1:0] ACC_HI = {{(WIDE-SUM_WIDTH){1'b0}}, SUM_MAX};
    localparam logic signed [WIDE-1:0] ACC_LO = {{(WIDE-SUM_WIDTH){1'b1}}, SUM_MIN};

    typedef struct packed {
        logic [SUM_WIDTH-1:0] integral;
        logic                 zero_width;
        logic                 clamped;
    } t_integral_result;

    // Predicted state of the integrator.
    logic signed [SAMPLE_WIDTH-1:0] prev2_x, prev2_y, prev1_x, prev1_y;
    logic [CNT_WIDTH-1:0]           sample_index;
    logic signed [SUM_WIDTH-1:0]    integral_acc;
    logic                           zero_width_seen;
    logic                           clamp_seen;

    t_integral_result expected_integrals[$];
    int               mismatch_count;

    // Takes one accepted sample: adds the term of a completed pair of intervals and, on
    // the final sample of a run, stores the expected result and clears the run state.
    task automatic integrate_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                                    input logic signed [SAMPLE_WIDTH-1:0] y,
                                    input logic last);
        logic signed [WIDE-1:0] x0, x1, x2, y0, y1, y2;
        logic signed [WIDE-1:0] h0, h1, hs, num, den, term, acc;
        if (sample_index >= 2 && !sample_index[0]) begin
            x0 = prev2_x;
            y0 = prev2_y;
            x1 = prev1_x;
            y1 = prev1_y;
            x2 = x;
            y2 = y;
            h0 = x1 - x0;
            h1 = x2 - x1;
            hs = h0 + h1;
            if (h0 == 0 || h1 == 0) begin
                // A zero-width interval skips the whole pair.
                zero_width_seen = 1'b1;
            end else begin
                num  = (y0 * (2 * h0 - h1) * h1 + y1 * hs * hs + y2 * (2 * h1 - h0) * h0) * hs;
                den  = (6 * h0 * h1) <<< FRAC_BITS;
                term = num / den;
                if (term > ACC_HI) begin
                    term       = ACC_HI;
                    clamp_seen = 1'b1;
                end else if (term < ACC_LO) begin
                    term       = ACC_LO;
                    clamp_seen = 1'b1;
                end
                acc = integral_acc + term;
                if (acc > ACC_HI) begin
                    acc        = ACC_HI;
                    clamp_seen = 1'b1;
                end else if (acc < ACC_LO) begin
                    acc        = ACC_LO;
                    clamp_seen = 1'b1;
                end
                integral_acc = acc[SUM_WIDTH-1:0];
            end
        end
        prev2_x      = prev1_x;
        prev2_y      = prev1_y;
        prev1_x      = x;
        prev1_y      = y;
        sample_index = (sample_index == CNT_MAX) ? CNT_WRAP : sample_index + 1'b1;
        if (last) begin
            expected_integrals.push_back('{integral_acc, zero_width_seen, clamp_seen});
            prev2_x         = '0;
            prev2_y         = '0;
            prev1_x         = '0;
            prev1_y         = '0;
            sample_index    = '0;
            integral_acc    = '0;
            zero_width_seen = 1'b0;
            clamp_seen      = 1'b0;
        end
    endtask

    // Result transactions are checked before the sample of the same edge is taken.
    always @(posedge i_clk) begin
        t_integral_result want, got;
        if (!i_rst_n) begin
            prev2_x         = '0;
            prev2_y         = '0;
            prev1_x         = '0;
            prev1_y         = '0;
            sample_index    = '0;
            integral_acc    = '0;
            zero_width_seen = 1'b0;
            clamp_seen      = 1'b0;
            mismatch_count  = 0;
            expected_integrals.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_integral, i_zero_interval_error, i_saturated};
                if (expected_integrals.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: integral %h zero_interval_error %b %s %b",
                                 got.integral, got.zero_width, "saturated", got.clamped);
                    mismatch_count++;
                end else begin
                    want = expected_integrals.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display({"result mismatch: integral exp %h got %h, ",
                                      "zero_interval_error exp %b got %b, ",
                                      "saturated exp %b got %b"},
                                     want.integral, got.integral, want.zero_width,
                                     got.zero_width, want.clamped, got.clamped);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                integrate_sample(i_sample_x, i_sample_y, i_last);
        end
        o_outstanding <= expected_integrals.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

### verif/testbench.sv
module testbench;
    import nsi_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int SAMPLE_TARGET = 1800;
    localparam logic [SAMPLE_WIDTH-1:0] Q_ONE = 1 << FRAC_BITS;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_WIDTH-1:0] sample_x     = '0;
    logic [SAMPLE_WIDTH-1:0] sample_y     = '0;
    logic                    sample_last  = 1'b0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [SUM_WIDTH-1:0]    integral;
    logic                    zero_interval_error;
    logic                    saturated;

    int   mismatch_count;
    int   results_outstanding;
    int   cycle_count  = 0;
    int   samples_sent = 0;
    logic tx_eager     = 1'b0;

    nonuniform_simpson_integrator u_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_valid               (in_valid),
        .o_ready               (in_ready),
        .i_sample_x            (sample_x),
        .i_sample_y            (sample_y),
        .i_last                (sample_last),
        .o_valid               (out_valid),
        .i_ready               (out_ready),
        .o_integral            (integral),
        .o_zero_interval_error (zero_interval_error),
        .o_saturated           (saturated)
    );

    simpson_result_checker u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .i_in_ready            (in_ready),
        .i_sample_x            (sample_x),
        .i_sample_y            (sample_y),
        .i_last                (sample_last),
        .i_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .i_integral            (integral),
        .i_zero_interval_error (zero_interval_error),
        .i_saturated           (saturated),
        .o_mismatches          (mismatch_count),
        .o_outstanding         (results_outstanding)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Watchdog on the total run length.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** nonuniform_simpson_integrator: FAILED **");
        $finish;
    end

    // Result side: a random stall before each transaction, with stretches of none.
    initial begin
        int   stall;
        logic rx_eager;
        rx_eager = 1'b0;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 5) == 0)
                rx_eager = !rx_eager;
            stall = rx_eager ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Presents one sample after a random gap and holds it until the transaction completes.
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x,
                               input logic [SAMPLE_WIDTH-1:0] y,
                               input logic last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_x    <= x;
        sample_y    <= y;
        sample_last <= last;
        do @(posedge clk); while (!(in_valid && in_ready));
        samples_sent++;
    endtask

    initial begin
        int                      run_len, kind, step_max, y_shift, k;
        logic [SAMPLE_WIDTH-1:0] x, y, step;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Runs of one and two samples give zero.
        send_sample(Q_ONE, 5 * Q_ONE, 1'b1);
        send_sample(0, Q_ONE, 1'b0);
        send_sample(Q_ONE, 2 * Q_ONE, 1'b1);
        // Uniform spacing, one pair.
        send_sample(0, Q_ONE, 1'b0);
        send_sample(Q_ONE, 4 * Q_ONE, 1'b0);
        send_sample(2 * Q_ONE, 9 * Q_ONE, 1'b1);
        // Nonuniform spacing with a trailing odd interval that is dropped.
        send_sample(0, -Q_ONE, 1'b0);
        send_sample(Q_ONE / 2, 3 * Q_ONE, 1'b0);
        send_sample(2 * Q_ONE, -2 * Q_ONE, 1'b0);
        send_sample(3 * Q_ONE, 7, 1'b1);
        // Zero-width first interval, then a zero-width second interval.
        send_sample(5 * Q_ONE, Q_ONE, 1'b0);
        send_sample(5 * Q_ONE, 2 * Q_ONE, 1'b0);
        send_sample(6 * Q_ONE, 3 * Q_ONE, 1'b0);
        send_sample(7 * Q_ONE, 4 * Q_ONE, 1'b0);
        send_sample(7 * Q_ONE, 5 * Q_ONE, 1'b1);
        // Decreasing abscissae.
        send_sample(3 * Q_ONE, Q_ONE, 1'b0);
        send_sample(Q_ONE, -Q_ONE, 1'b0);
        send_sample(-2 * Q_ONE, 2 * Q_ONE, 1'b1);
        // Extreme fields: a term far beyond the sum range.
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0001, 32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // Raw steps of one with the most negative ordinates.
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0001, 32'h8000_0000, 1'b1);

        // Random runs: mostly nondecreasing meshes, some with backward steps, some noise.
        while (samples_sent < SAMPLE_TARGET) begin
            run_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
            kind     = $urandom_range(0, 9);
            tx_eager = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: step_max = 16;
                1: step_max = 4 * Q_ONE;
                2: step_max = 32'h0100_0000;
                default: step_max = 32'h0800_0000;
            endcase
            y_shift = $urandom_range(0, 28);
            x       = $signed($urandom) >>> $urandom_range(0, 31);
            for (k = 0; k < run_len; k++) begin
                if (kind >= 8) begin
                    x = $urandom;
                    y = $urandom;
                end else begin
                    if (k != 0) begin
                        step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max);
                        if (kind == 7 && $urandom_range(0, 3) == 0)
                            step = -step;
                        x = x + step;
                    end
                    y = $signed($urandom) >>> y_shift;
                end
                send_sample(x, y, k == run_len - 1);
            end
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow a full pair time for stray output.
        @(posedge clk);
        while (results_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("** nonuniform_simpson_integrator: PASSED **");
        else
            $display("** nonuniform_simpson_integrator: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/core/nsi_pkg.sv
rtl/core/nsi_addsub.sv
rtl/core/nsi_term.sv
rtl/core/nonuniform_simpson_integrator.sv
verif/simpson_result_checker.sv
verif/testbench.sv
